// ===== hw/rtl/assert_macros.svh =====
// assertion helpers for the rtl files, included by rule110_ring_run_and_distance.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the rising edge of clk, off while arst_n is low
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// same, for a property that must hold also while reset is applied
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hw/rtl/r110_pkg.sv =====
`default_nettype none

package r110_pkg;

	localparam int unsigned ROW_W     = 64;
	localparam int unsigned GEN_W     = 10;
	localparam int unsigned DIST_W    = 7;
	localparam int unsigned GRP_W     = 8;
	localparam int unsigned GRP_N     = ROW_W / GRP_W;
	localparam int unsigned GRP_CNT_W = 4;
	localparam int unsigned IN_W      = 2 * ROW_W;
	localparam int unsigned OUT_W     = 72;

	localparam logic [GEN_W-1:0] GEN_DEFAULT = 10'd100;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_SUM,
		ST_DONE
	} r110_state_t;

	typedef struct packed {
		logic load;
		logic step;
	} cell_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/r110_cell.sv =====
`default_nettype none

module r110_cell (
	input  wire                   clk,
	input  r110_pkg::cell_ctrl_t  ctrl,
	input  wire                   load_bit,
	input  wire                   load_tgt,
	input  wire                   left,
	input  wire                   right,
	output logic                  state,
	output logic                  diff
);
	import r110_pkg::*;

	logic cell_q;
	logic tgt_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			cell_q <= load_bit;
			tgt_q  <= load_tgt;
		end else if (ctrl.step) begin
			// rule 110: alive for 001 010 011 101 110
			cell_q <= (cell_q ^ right) | (cell_q & ~left);
		end
	end

	assign state = cell_q;
	assign diff  = cell_q ^ tgt_q;

endmodule

`default_nettype wire

// ===== hw/rtl/r110_popcount.sv =====
`default_nettype none

module r110_popcount (
	input  wire                          clk,
	input  wire                          en,
	input  wire  [r110_pkg::ROW_W-1:0]   diff,
	output logic [r110_pkg::DIST_W-1:0]  total
);
	import r110_pkg::*;

	logic [GRP_CNT_W-1:0] grp_s1 [GRP_N];

	function automatic logic [GRP_CNT_W-1:0] grp_count(input logic [GRP_W-1:0] v);
		logic [GRP_CNT_W-1:0] n;
		n = '0;
		for (int i = 0; i < GRP_W; i++) begin
			n = n + {{(GRP_CNT_W-1){1'b0}}, v[i]};
		end
		return n;
	endfunction

	// first level: one count per byte of the difference row
	always_ff @(posedge clk) begin
		if (en) begin
			for (int g = 0; g < GRP_N; g++) begin
				grp_s1[g] <= grp_count(diff[g*GRP_W +: GRP_W]);
			end
		end
	end

	always_comb begin
		total = '0;
		for (int g = 0; g < GRP_N; g++) begin
			total = total + {{(DIST_W-GRP_CNT_W){1'b0}}, grp_s1[g]};
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/rule110_ring_run_and_distance.sv =====
// Runs elementary rule 110 on a ring of CELLS cells: a beat on s_axis loads the start row
// and the target row, the ring then advances one generation per clock for the number of
// generations held in the configuration register (reset 100, written over cfg_data), and
// one beat on m_axis returns the final row and its Hamming distance to the target. After
// the input beat the cell chain steps once per generation; in the state that sees the
// terminal count the per-byte difference counts are registered, the sum state follows, and
// in the done state, once the output register is free, the byte counts are added into it.
// One item is in the ring at a time; a new input beat is taken as soon as the ring is
// free, even while the previous result still waits in the output register.
// Bits at and above CELLS of the input rows are ignored and read back as zero.
`default_nettype none

module rule110_ring_run_and_distance #(
	parameter int unsigned CELLS = 64
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_valid,
	output logic                         cfg_ready,
	input  wire  [r110_pkg::GEN_W-1:0]   cfg_data,
	input  wire                          s_axis_tvalid,
	output logic                         s_axis_tready,
	// [63:0] start_row, [127:64] target_row
	input  wire  [r110_pkg::IN_W-1:0]    s_axis_tdata,
	output logic                         m_axis_tvalid,
	input  wire                          m_axis_tready,
	// [63:0] final_row, [70:64] distance, [71] zero
	output logic [r110_pkg::OUT_W-1:0]   m_axis_tdata
);
	import r110_pkg::*;

	`include "assert_macros.svh"

	r110_state_t         state_q, state_d;
	logic [GEN_W-1:0]    generations_q;
	logic [GEN_W-1:0]    gen_q;
	cell_ctrl_t          cell_ctrl;
	logic                sum_en;
	logic                out_load;
	logic                out_valid_q;
	logic [ROW_W-1:0]    final_row_q;
	logic [DIST_W-1:0]   distance_q;
	logic [ROW_W-1:0]    row_w;
	logic [ROW_W-1:0]    diff_w;
	logic [DIST_W-1:0]   total_w;
	logic                in_beat;
	logic                out_free;
	logic                gen_done;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_beat       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign gen_done      = (gen_q == generations_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			generations_q <= GEN_DEFAULT;
		end else if (cfg_valid && cfg_ready) begin
			generations_q <= cfg_data;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_beat) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (gen_done) begin
					state_d = ST_SUM;
				end
			end
			ST_SUM: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control outputs
	always_comb begin
		cell_ctrl.load = 1'b0;
		cell_ctrl.step = 1'b0;
		sum_en         = 1'b0;
		out_load       = 1'b0;
		case (state_q)
			ST_IDLE: begin
				cell_ctrl.load = in_beat;
			end
			ST_RUN: begin
				cell_ctrl.step = !gen_done;
				sum_en         = gen_done;
			end
			ST_SUM: begin
			end
			ST_DONE: begin
				out_load = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			gen_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cell_ctrl.load) begin
				gen_q <= '0;
			end else if (cell_ctrl.step) begin
				gen_q <= gen_q + 1'b1;
			end
		end
	end

	// ring of cells, neighbors wrap around
	for (genvar k = 0; k < ROW_W; k++) begin : g_cell
		if (k < CELLS) begin : g_live
			r110_cell u_cell (
				.clk      (clk),
				.ctrl     (cell_ctrl),
				.load_bit (s_axis_tdata[k]),
				.load_tgt (s_axis_tdata[ROW_W + k]),
				.left     (row_w[(k + CELLS - 1) % CELLS]),
				.right    (row_w[(k + 1) % CELLS]),
				.state    (row_w[k]),
				.diff     (diff_w[k])
			);
		end else begin : g_pad
			assign row_w[k]  = 1'b0;
			assign diff_w[k] = 1'b0;
		end
	end

	r110_popcount u_popcount (
		.clk   (clk),
		.en    (sum_en),
		.diff  (diff_w),
		.total (total_w)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			final_row_q <= row_w;
			distance_q  <= total_w;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_W-ROW_W-DIST_W){1'b0}}, distance_q, final_row_q};

	`ASSERT_CLK(a_load_starts_run, in_beat |=> (state_q == ST_RUN), "input beat did not start a run")
	`ASSERT_CLK(a_gen_bounded, (state_q == ST_RUN) |-> (gen_q <= generations_q), "generation count overran")
	`ASSERT_CLK(a_result_from_done, $rose(out_valid_q) |-> $past(state_q == ST_DONE), "result appeared outside done")
	`ASSERT_CLK(a_dist_range, out_valid_q |-> (distance_q <= DIST_W'(CELLS)), "distance above ring size")

endmodule

`default_nettype wire
